@@ hdl/dq_pkg.sv @@
// shared types and constants for the double-ended queue
// no dependencies; imported by dq_ctrl, dq_datapath and double_ended_queue_top
`default_nettype none

package dq_pkg;

   // default sizes
   localparam int DEPTH_DEF     = 16;
   localparam int WORD_BITS_DEF = 32;
   localparam int OP_BITS       = 3;
   localparam int STATUS_BITS   = 2;

   // operation codes; codes above peek back do nothing
   typedef enum logic [OP_BITS-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_PEEK_FRONT = 3'd4,
      OP_PEEK_BACK  = 3'd5
   } dq_op_type;

   // result status codes
   typedef enum logic [STATUS_BITS-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } dq_status_type;

   // controller states
   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_LOAD
   } dq_state_type;

   // controller to datapath commands
   typedef struct packed {
      logic take;   // capture the request transaction
      logic exec;   // update pointers, write or read the store
      logic load;   // move the result into the output register
   } dq_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic rsp_free;   // output register can take a result this cycle
   } dq_stat_type;

endpackage

`default_nettype wire

@@ hdl/dq_ctrl.sv @@
// controller state machine for the double-ended queue
// depends on dq_pkg for the state, command and status types
`default_nettype none

module dq_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire dq_pkg::dq_stat_type stat,
   output dq_pkg::dq_cmd_type      cmd
);
   import dq_pkg::*;

   dq_state_type state_ff;
   dq_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            // wait here while the previous result is still unread
            if (stat.rsp_free) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ hdl/dq_datapath.sv @@
// datapath of the double-ended queue: circular store, pointers, count, output register
// depends on dq_pkg for operation, status, command and status types
`default_nettype none

module dq_datapath #(
   parameter int DEPTH     = dq_pkg::DEPTH_DEF,
   parameter int WORD_BITS = dq_pkg::WORD_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire dq_pkg::dq_cmd_type            cmd,
   output dq_pkg::dq_stat_type                stat,
   input  wire logic [dq_pkg::OP_BITS-1:0]    req_operation,
   input  wire logic signed [WORD_BITS-1:0]   req_push_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [WORD_BITS-1:0]        rsp_result_value,
   output logic [dq_pkg::STATUS_BITS-1:0]     rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]         rsp_occupancy
);
   import dq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

   // captured request
   dq_op_type            op_ff;
   logic [WORD_BITS-1:0] word_ff;

   // queue state
   logic [WORD_BITS-1:0] entry_store_ff [DEPTH];
   logic [AW-1:0]        head_ff, head_in;
   logic [AW-1:0]        tail_ff, tail_in;
   logic [CW-1:0]        count_ff, count_in;

   // per-transaction outcome
   dq_status_type        status_ff, status_in;
   logic                 use_read_ff, use_read_in;
   logic [WORD_BITS-1:0] rd_data_ff;

   // output register
   logic                 rsp_valid_ff;
   logic [WORD_BITS-1:0] rsp_value_ff, rsp_value_in;
   dq_status_type        rsp_status_ff;
   logic [CW-1:0]        rsp_occ_ff;

   // store access
   logic                 wr_en, rd_en;
   logic [AW-1:0]        wr_addr, rd_addr;

   logic                 is_full, is_empty;
   logic [AW-1:0]        head_prev, head_next, tail_prev, tail_next;

   assign is_full   = (count_ff == CW'(DEPTH));
   assign is_empty  = (count_ff == '0);
   assign head_prev = (head_ff == '0) ? LAST_SLOT : head_ff - AW'(1);
   assign head_next = (head_ff == LAST_SLOT) ? '0 : head_ff + AW'(1);
   assign tail_prev = (tail_ff == '0) ? LAST_SLOT : tail_ff - AW'(1);
   assign tail_next = (tail_ff == LAST_SLOT) ? '0 : tail_ff + AW'(1);

   // capture the request transaction
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         op_ff   <= dq_op_type'(req_operation);
         word_ff <= req_push_value;
      end
   end

   // operation decode: pointer moves, store access, status
   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      status_in   = STAT_OK;
      use_read_in = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = tail_ff;
      rd_en       = 1'b0;
      rd_addr     = head_ff;
      case (op_ff)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (is_full) begin
               status_in = STAT_FULL;
            end else begin
               wr_en    = cmd.exec;
               count_in = count_ff + CW'(1);
               if (op_ff == OP_PUSH_FRONT) begin
                  head_in = head_prev;
                  wr_addr = head_prev;
               end else begin
                  tail_in = tail_next;
                  wr_addr = tail_ff;
               end
            end
         end
         OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
            if (is_empty) begin
               status_in = STAT_EMPTY;
            end else begin
               rd_en       = cmd.exec;
               use_read_in = 1'b1;
               case (op_ff)
                  OP_POP_FRONT: begin
                     rd_addr  = head_ff;
                     head_in  = head_next;
                     count_in = count_ff - CW'(1);
                  end
                  OP_POP_BACK: begin
                     rd_addr  = tail_prev;
                     tail_in  = tail_prev;
                     count_in = count_ff - CW'(1);
                  end
                  OP_PEEK_FRONT: begin
                     rd_addr = head_ff;
                  end
                  default: begin
                     rd_addr = tail_prev;
                  end
               endcase
            end
         end
         default: begin
            // unused codes leave everything as is
         end
      endcase
   end

   // pointer and count registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.exec) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // outcome of the executed transaction
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff   <= status_in;
         use_read_ff <= use_read_in;
      end
   end

   // circular store with registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_store_ff[wr_addr] <= word_ff;
      end
      if (rd_en) begin
         rd_data_ff <= entry_store_ff[rd_addr];
      end
   end

   // result word: read data, all ones on underflow, zero otherwise
   always_comb begin
      if (use_read_ff) begin
         rsp_value_in = rd_data_ff;
      end else if (status_ff == STAT_EMPTY) begin
         rsp_value_in = '1;
      end else begin
         rsp_value_in = '0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= status_ff;
         rsp_occ_ff    <= count_ff;
      end
   end

   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_occupancy    = rsp_occ_ff;

endmodule

`default_nettype wire

@@ hdl/double_ended_queue_top.sv @@
// Bounded double-ended queue of signed words held in a circular store.
// Request channel (req_valid/req_ready): req_operation selects push front,
// push back, pop front, pop back, peek front or peek back; req_push_value is
// the word to insert on a push. Every request transaction gives exactly one
// response transaction (rsp_valid/rsp_ready) with rsp_result_value,
// rsp_status (ok, empty, full) and rsp_occupancy after the operation.
// After a request is accepted, the pointers are updated with the store access,
// then the result moves into the output register once that register is free.
// A request is not taken until the store read and the pointer update of the
// previous operation have finished and its result has left the datapath.
// A new request is taken while the previous response still waits in the
// output register; if the receiver stalls longer, the next result waits in
// the datapath and req_ready stays low until the output register frees.
// Reset empties the queue (pointers and count to zero); store contents are
// left as they are and are never read before being written.
// Depends on dq_pkg, dq_ctrl and dq_datapath.
`default_nettype none

module double_ended_queue_top #(
   parameter int DEPTH     = dq_pkg::DEPTH_DEF,
   parameter int WORD_BITS = dq_pkg::WORD_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [dq_pkg::OP_BITS-1:0]    req_operation,
   input  wire logic signed [WORD_BITS-1:0]   req_push_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [WORD_BITS-1:0]        rsp_result_value,
   output logic [dq_pkg::STATUS_BITS-1:0]     rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]         rsp_occupancy
);
   import dq_pkg::*;

   dq_cmd_type  cmd;
   dq_stat_type stat;

   // sequencing of each transaction
   dq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // store, pointers and output stage
   dq_datapath #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_operation    (req_operation),
      .req_push_value   (req_push_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status),
      .rsp_occupancy    (rsp_occupancy)
   );

endmodule

`default_nettype wire
